// ===== hdl/dfc_pkg.sv =====
// Shared constants, types and the digit font table for the decimal font column streamer.
package dfc_pkg;

  // Display geometry
  localparam int unsigned NUM_DIGITS    = 4;
  localparam int unsigned GLYPH_COLUMNS = 5;

  // Field widths
  localparam int unsigned VALUE_W = 14;
  localparam int unsigned COLS_W  = 7;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned DIGIT_W = 4;

  // Counter width for a digit index, at least one bit
  localparam int unsigned DIG_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // Divide by ten as multiply by reciprocal: exact for every 14-bit value
  localparam int unsigned DIV10_MULT  = 6554;
  localparam int unsigned DIV10_MW    = 13;
  localparam int unsigned DIV10_SHIFT = 16;
  localparam int unsigned PROD_W      = VALUE_W + DIV10_MW;
  localparam int unsigned QUO_W       = PROD_W - DIV10_SHIFT;

  localparam int unsigned FONT_DIGITS = 10;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // Finished conversion handed from the converter to the column streamer
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } hand_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_HOLD
  } conv_state_e;

  // 5x7 glyphs for 0..9, bit 0 is the top row
  localparam logic [COLS_W-1:0] FONT_ROM [FONT_DIGITS][GLYPH_COLUMNS] = '{
    '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
    '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
    '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
    '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
    '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
    '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
    '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
    '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}
  };

  // Look up one glyph column; codes outside the table read as blank
  function automatic logic [COLS_W-1:0] font_col(input logic [DIGIT_W-1:0] digit,
                                                 input logic [CIDX_W-1:0]  col);
    logic [COLS_W-1:0] bits;
    bits = '0;
    if (digit < DIGIT_W'(FONT_DIGITS) && col < CIDX_W'(GLYPH_COLUMNS)) begin
      bits = FONT_ROM[digit][col];
    end
    return bits;
  endfunction

endpackage

// ===== hdl/dfc_in_if.sv =====
// Input channel: one value to display per transfer.
interface dfc_in_if;
  logic                            valid;
  logic                            ready;
  logic [dfc_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== hdl/dfc_out_if.sv =====
// Output channel: one font column per transfer.
interface dfc_out_if;
  logic                            valid;
  logic                            ready;
  logic [dfc_pkg::COLS_W-1:0]      column_bits;
  logic [dfc_pkg::POS_W-1:0]       digit_position;
  logic [dfc_pkg::CIDX_W-1:0]      column_index;
  logic                            last;

  modport source (output valid, output column_bits, output digit_position,
                  output column_index, output last, input ready);
  modport sink (input valid, input column_bits, input digit_position,
                input column_index, input last, output ready);
endinterface

// ===== hdl/dfc_conv.sv =====
// Binary to decimal converter: one digit per cycle, least significant first.
module dfc_conv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [dfc_pkg::VALUE_W-1:0]  in_value_i,
  output logic                         in_ready_o,
  input  logic                         take_i,
  output dfc_pkg::hand_t               hand_o
);

  dfc_pkg::conv_state_e             state_q, state_d;
  logic [dfc_pkg::DIG_IDX_W-1:0]    cnt_q, cnt_d;
  logic [dfc_pkg::VALUE_W-1:0]      val_q, val_d;
  dfc_pkg::digits_t                 digits_q;
  logic [dfc_pkg::PROD_W-1:0]       prod;
  logic [dfc_pkg::QUO_W-1:0]        quo;
  logic [dfc_pkg::VALUE_W-1:0]      rem_full;
  logic                             step;

  // Quotient and remainder of the working value by ten
  assign prod     = dfc_pkg::PROD_W'(val_q) * dfc_pkg::PROD_W'(dfc_pkg::DIV10_MULT);
  assign quo      = prod[dfc_pkg::PROD_W-1:dfc_pkg::DIV10_SHIFT];
  assign rem_full = val_q - (dfc_pkg::VALUE_W'(quo) * dfc_pkg::VALUE_W'(10));

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    in_ready_o = 1'b0;
    step       = 1'b0;
    case (state_q)
      dfc_pkg::CONV_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d   = in_value_i;
          cnt_d   = dfc_pkg::DIG_IDX_W'(dfc_pkg::NUM_DIGITS - 1);
          state_d = dfc_pkg::CONV_RUN;
        end
      end
      dfc_pkg::CONV_RUN: begin
        step  = 1'b1;
        val_d = dfc_pkg::VALUE_W'(quo);
        if (cnt_q == '0) begin
          state_d = dfc_pkg::CONV_HOLD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      dfc_pkg::CONV_HOLD: begin
        if (take_i) begin
          state_d = dfc_pkg::CONV_IDLE;
        end
      end
      default: begin
        state_d = dfc_pkg::CONV_IDLE;
      end
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfc_pkg::CONV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the working value and store each digit
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    val_q <= val_d;
    if (step) begin
      digits_q[cnt_q] <= rem_full[dfc_pkg::DIGIT_W-1:0];
    end
  end

  assign hand_o.valid  = (state_q == dfc_pkg::CONV_HOLD);
  assign hand_o.digits = digits_q;

  // Remainder of a divide by ten is a decimal digit
  a_rem_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> rem_full < dfc_pkg::VALUE_W'(10))
    else $error("converter remainder out of range");

  // Last digit step ends in hold
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfc_pkg::CONV_RUN && cnt_q == '0) |=> state_q == dfc_pkg::CONV_HOLD)
    else $error("converter did not finish after last digit");

  // Offered digits stay put until taken
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hand_o.valid && !take_i) |=> hand_o.valid && $stable(digits_q))
    else $error("converter result changed before handoff");

endmodule

// ===== hdl/decimal_font_column_streamer_core.sv =====
// Top level: decimal conversion followed by font column streaming from a registered ROM.
//
//  Channel | Dir | Handshake    | Payload
//  in_i    | in  | valid/ready  | value[13:0]
//  out_o   | out | valid/ready  | column_bits[6:0], digit_position[1:0], column_index[2:0], last
//
// Each value yields NUM_DIGITS*GLYPH_COLUMNS = 20 column transfers, one per cycle unless out_o
// stalls; the font ROM read port, one column a cycle, sets that rate. The converter works on
// the next value while columns stream, and its result is loaded as the last column is read.
// When idle, the first column follows the input transfer through conversion, load and ROM read.
// Reset (rst_ni low, asynchronous) empties converter and streamer; no clearing pass.
// A stall on out_o holds the current column; the ROM reads again only once it is taken.
module decimal_font_column_streamer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  dfc_in_if.sink         in_i,
  dfc_out_if.source      out_o
);

  dfc_pkg::hand_t                   hand;
  dfc_pkg::digits_t                 digits_q;
  logic [dfc_pkg::DIG_IDX_W-1:0]    dpos_q;
  logic [dfc_pkg::CIDX_W-1:0]       col_q;
  logic                             active_q;
  logic                             out_valid_q;
  logic [dfc_pkg::COLS_W-1:0]       col_bits_q;
  logic [dfc_pkg::POS_W-1:0]        pos_q;
  logic [dfc_pkg::CIDX_W-1:0]       cidx_q;
  logic                             last_q;
  logic [dfc_pkg::DIG_IDX_W+1:0]    dpos_ext;
  logic                             at_last;
  logic                             col_end;
  logic                             rd_en;
  logic                             load;

  dfc_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_value_i (in_i.value),
    .in_ready_o (in_i.ready),
    .take_i     (load),
    .hand_o     (hand)
  );

  // Sequencing of the column reads
  assign col_end  = (col_q == dfc_pkg::CIDX_W'(dfc_pkg::GLYPH_COLUMNS - 1));
  assign at_last  = col_end && (dpos_q == dfc_pkg::DIG_IDX_W'(dfc_pkg::NUM_DIGITS - 1));
  assign rd_en    = active_q && (!out_valid_q || out_o.ready);
  assign load     = hand.valid && (!active_q || (rd_en && at_last));
  assign dpos_ext = {2'b00, dpos_q};

  // Advance through digits and columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dpos_q   <= '0;
      col_q    <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      dpos_q   <= '0;
      col_q    <= '0;
    end else if (rd_en) begin
      if (at_last) begin
        active_q <= 1'b0;
      end else if (col_end) begin
        col_q  <= '0;
        dpos_q <= dpos_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Latch the digits of the run being streamed
  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= hand.digits;
    end
  end

  // Output valid: set by a ROM read, dropped once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Font ROM with registered read data and matching column tags
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      col_bits_q <= dfc_pkg::font_col(digits_q[dpos_q], col_q);
      pos_q      <= dpos_ext[dfc_pkg::POS_W-1:0];
      cidx_q     <= col_q;
      last_q     <= at_last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.column_bits    = col_bits_q;
  assign out_o.digit_position = pos_q;
  assign out_o.column_index   = cidx_q;
  assign out_o.last           = last_q;

  // A ROM read always lands in the output register
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> out_valid_q)
    else $error("ROM read lost");

  // A new run starts at the first column of the first digit
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> active_q && dpos_q == '0 && col_q == '0)
    else $error("run did not start at first column");

  // Position holds while the output is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !rd_en && !load) |=> $stable(dpos_q) && $stable(col_q))
    else $error("column position moved during stall");

  // The final column of a run carries the last flag on its transfer
  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && at_last) |=> last_q)
    else $error("final column not marked last");

endmodule
